FILE: sv/ascii_escape_parser_macros.svh
// Assertion macros used by the escape parser top level.
`ifndef ASCII_ESCAPE_PARSER_MACROS_SVH
`define ASCII_ESCAPE_PARSER_MACROS_SVH

`ifndef SYNTHESIS
`define AEP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("aep assertion failed");
`define AEP_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aep implication failed");
`else
`define AEP_ASSERT(lbl, prop)
`define AEP_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

FILE: sv/aep_pkg.sv
// Types, codes and character constants for the escape parser.
`default_nettype none

package aep_pkg;

  localparam int OFFSET_BITS_DEF = 16;

  // code units recognized by the parser
  localparam logic [15:0] CU_SPACE  = 16'h0020;
  localparam logic [15:0] CU_TILDE  = 16'h007E;
  localparam logic [15:0] CU_DEL    = 16'h007F;
  localparam logic [15:0] CU_BSLASH = 16'h005C;
  localparam logic [15:0] CU_LOW_R  = 16'h0072;
  localparam logic [15:0] CU_LOW_N  = 16'h006E;
  localparam logic [15:0] CU_LOW_T  = 16'h0074;
  localparam logic [15:0] CU_ZERO   = 16'h0030;
  localparam logic [15:0] CU_LOW_X  = 16'h0078;
  localparam logic [15:0] CU_NINE   = 16'h0039;
  localparam logic [15:0] CU_UP_A   = 16'h0041;
  localparam logic [15:0] CU_UP_F   = 16'h0046;

  // decoded escape bytes
  localparam logic [6:0] BY_BSLASH = 7'h5C;
  localparam logic [6:0] BY_CR     = 7'h0D;
  localparam logic [6:0] BY_LF     = 7'h0A;
  localparam logic [6:0] BY_TAB    = 7'h09;
  localparam logic [6:0] BY_NUL    = 7'h00;

  typedef enum logic [2:0] {
    PH_TEXT   = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX_HI = 3'd2,
    PH_HEX_LO = 3'd3,
    PH_DRAIN  = 3'd4
  } aep_phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NONASCII = 3'd1,
    ERR_CONTROL  = 3'd2,
    ERR_TRAILING = 3'd3,
    ERR_BADHEX   = 3'd4,
    ERR_RANGE    = 3'd5,
    ERR_UNKNOWN  = 3'd6
  } aep_err_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  val;
  } aep_nib_t;

  typedef struct packed {
    logic        valid;
    logic [6:0]  out_byte;
    logic        has_byte;
    logic        error_flag;
    aep_err_t    error_code;
    logic [15:0] fail_offset;
    logic        done_res;
  } aep_res_t;

  // uppercase hex digit to nibble
  function automatic aep_nib_t hex_nibble(input logic [15:0] cu);
    aep_nib_t n;
    n = '0;
    if (cu >= CU_ZERO && cu <= CU_NINE) begin
      n.ok  = 1'b1;
      n.val = cu[3:0];
    end else if (cu >= CU_UP_A && cu <= CU_UP_F) begin
      n.ok  = 1'b1;
      n.val = 4'(cu[3:0] + 4'd9);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

FILE: sv/aep_decode.sv
// Phase and offset state with the per-unit decode logic.
`default_nettype none

module aep_decode import aep_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        fire,
  input  wire logic [15:0] code_unit,
  input  wire logic        last_unit,
  output aep_res_t         res
);

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

  aep_phase_t             phase_r, phase_nxt;
  logic [OFFSET_BITS-1:0] unit_off_r, unit_off_nxt;
  logic [OFFSET_BITS-1:0] esc_start_r, esc_start_nxt;
  logic [3:0]             hi_nib_r, hi_nib_nxt;
  logic                   hi_inv_r, hi_inv_nxt;

  logic [OFFSET_BITS:0]    off_inc, esc_plus2;
  logic [OFFSET_BITS-1:0]  off_inc_sat, esc_plus2_sat, err_off;
  logic [OFFSET_BITS+15:0] err_off_ext;
  aep_nib_t               nib;
  logic                   emit_b, emit_e;
  logic [6:0]             byte_v;
  aep_err_t               code;

  assign off_inc       = {1'b0, unit_off_r} + (OFFSET_BITS+1)'(1);
  assign esc_plus2     = {1'b0, esc_start_r} + (OFFSET_BITS+1)'(2);
  assign off_inc_sat   = off_inc[OFFSET_BITS] ? OFF_MAX : off_inc[OFFSET_BITS-1:0];
  assign esc_plus2_sat = esc_plus2[OFFSET_BITS] ? OFF_MAX : esc_plus2[OFFSET_BITS-1:0];
  assign nib           = hex_nibble(code_unit);
  // reported offset is the low 16 bits, zero extended for narrow counters
  assign err_off_ext   = {16'd0, err_off};

  always_comb begin
    phase_nxt     = phase_r;
    esc_start_nxt = esc_start_r;
    hi_nib_nxt    = hi_nib_r;
    hi_inv_nxt    = hi_inv_r;
    emit_b        = 1'b0;
    emit_e        = 1'b0;
    byte_v        = '0;
    code          = ERR_NONE;
    err_off       = '0;

    unique case (phase_r)
      PH_DRAIN: begin
        // drop units until the end of the string
      end
      PH_ESC: begin
        phase_nxt = PH_TEXT;
        priority if (code_unit == CU_BSLASH) begin
          emit_b = 1'b1;
          byte_v = BY_BSLASH;
        end else if (code_unit == CU_LOW_R) begin
          emit_b = 1'b1;
          byte_v = BY_CR;
        end else if (code_unit == CU_LOW_N) begin
          emit_b = 1'b1;
          byte_v = BY_LF;
        end else if (code_unit == CU_LOW_T) begin
          emit_b = 1'b1;
          byte_v = BY_TAB;
        end else if (code_unit == CU_ZERO) begin
          emit_b = 1'b1;
          byte_v = BY_NUL;
        end else if (code_unit == CU_LOW_X) begin
          if (last_unit) begin
            emit_e  = 1'b1;
            code    = ERR_BADHEX;
            err_off = esc_start_r;
          end else begin
            phase_nxt = PH_HEX_HI;
          end
        end else begin
          emit_e  = 1'b1;
          code    = ERR_UNKNOWN;
          err_off = esc_start_r;
        end
      end
      PH_HEX_HI: begin
        hi_inv_nxt = ~nib.ok;
        hi_nib_nxt = nib.ok ? nib.val : 4'd0;
        if (last_unit) begin
          emit_e  = 1'b1;
          code    = ERR_BADHEX;
          err_off = esc_start_r;
        end else begin
          phase_nxt = PH_HEX_LO;
        end
      end
      PH_HEX_LO: begin
        phase_nxt = PH_TEXT;
        // first digit is judged only now, ahead of the second
        priority if (hi_inv_r) begin
          emit_e  = 1'b1;
          code    = ERR_BADHEX;
          err_off = esc_plus2_sat;
        end else if (!nib.ok) begin
          emit_e  = 1'b1;
          code    = ERR_BADHEX;
          err_off = unit_off_r;
        end else if (hi_nib_r[3]) begin
          emit_e  = 1'b1;
          code    = ERR_RANGE;
          err_off = esc_start_r;
        end else begin
          emit_b = 1'b1;
          byte_v = {hi_nib_r[2:0], nib.val};
        end
      end
      default: begin
        phase_nxt = PH_TEXT;
        priority if (code_unit >= CU_SPACE && code_unit <= CU_TILDE &&
                     code_unit != CU_BSLASH) begin
          emit_b = 1'b1;
          byte_v = code_unit[6:0];
        end else if (code_unit != CU_BSLASH) begin
          emit_e  = 1'b1;
          code    = (code_unit > CU_DEL) ? ERR_NONASCII : ERR_CONTROL;
          err_off = unit_off_r;
        end else if (last_unit) begin
          emit_e  = 1'b1;
          code    = ERR_TRAILING;
          err_off = unit_off_r;
        end else begin
          esc_start_nxt = unit_off_r;
          phase_nxt     = PH_ESC;
        end
      end
    endcase

    if (emit_e) begin
      phase_nxt = PH_DRAIN;
    end
    if (last_unit) begin
      phase_nxt = PH_TEXT;
    end
    unit_off_nxt = last_unit ? '0 : off_inc_sat;

    res             = '0;
    res.valid       = emit_b | emit_e;
    res.out_byte    = byte_v;
    res.has_byte    = emit_b;
    res.error_flag  = emit_e;
    res.error_code  = code;
    res.fail_offset = err_off_ext[15:0];
    res.done_res    = emit_e | last_unit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_TEXT;
      unit_off_r  <= '0;
      esc_start_r <= '0;
      hi_nib_r    <= '0;
      hi_inv_r    <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      unit_off_r  <= unit_off_nxt;
      esc_start_r <= esc_start_nxt;
      hi_nib_r    <= hi_nib_nxt;
      hi_inv_r    <= hi_inv_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ascii_escape_parser.sv
// Top level of the backslash escape parser: input register, decode, result register.
`default_nettype none
`include "ascii_escape_parser_macros.svh"

// Decodes a stream of 16-bit code units, one per cycle while the output
// is not held back, into 7-bit bytes. Each accepted unit passes an input
// register, the decode logic and a result register; a unit that gives no
// result (backslash, escape and hex prefix digits, units dropped after an
// error) leaves no gap in the input. in_tready drops only when the result
// register is full and out_tready is low, so otherwise throughput is one
// unit per cycle. An error result always carries tlast; units after it
// are dropped up to the unit marked tlast, and any bytes already sent for
// that string are to be thrown away downstream. Offsets saturate at
// 2^OFFSET_BITS-1 and are reported in 16 bits.

module ascii_escape_parser import aep_pkg::*; #(
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] code_unit
  input  wire logic        in_tlast,   // last_unit
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [6:0] out_byte, [9:7] error_code,
                                       // [25:10] fail_offset, [31:26] zero
  output logic [1:0]       out_tuser,  // [0] has_byte, [1] error_flag
  output logic             out_tlast   // done_res
);

  logic        s1_valid_r, s1_valid_nxt;
  logic [15:0] s1_cu_r, s1_cu_nxt;
  logic        s1_last_r, s1_last_nxt;
  logic        out_valid_r, out_valid_nxt;
  aep_res_t    out_res_r, out_res_nxt;
  aep_res_t    dec_res;
  logic        s1_adv, in_req;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_req    = in_tvalid && in_tready;

  aep_decode #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (s1_adv),
    .code_unit (s1_cu_r),
    .last_unit (s1_last_r),
    .res       (dec_res)
  );

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s1_cu_nxt     = s1_cu_r;
    s1_last_nxt   = s1_last_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (in_req) begin
      s1_valid_nxt = 1'b1;
      s1_cu_nxt    = in_tdata;
      s1_last_nxt  = in_tlast;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = dec_res.valid;
      out_res_nxt   = dec_res;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_cu_r   <= s1_cu_nxt;
    s1_last_r <= s1_last_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.fail_offset, 3'(out_res_r.error_code),
                       out_res_r.out_byte};
  assign out_tuser  = {out_res_r.error_flag, out_res_r.has_byte};
  assign out_tlast  = out_res_r.done_res;

  // a result is either a byte or an error, never both
  `AEP_ASSERT_IMPLY(a_one_kind, out_valid_r, out_tuser[0] ^ out_tuser[1])
  // an error closes the string
  `AEP_ASSERT_IMPLY(a_err_last, out_valid_r && out_tuser[1], out_tlast)
  // byte results carry no error code or offset
  `AEP_ASSERT_IMPLY(a_byte_clean, out_valid_r && out_tuser[0], out_tdata[25:7] == 19'd0)
  // with the result register empty, the input side never stalls
  `AEP_ASSERT(a_no_false_stall, out_valid_r || in_tready)

endmodule

`default_nettype wire
